@@ design/ipv4_header_parser_unit_macros.svh @@
// ----------------------------------------------------------------------------
// ipv4_header_parser_unit_macros.svh
// Assertion macros shared by the IPv4 header parser checker.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_PARSER_UNIT_MACROS_SVH
`define IPV4_HEADER_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define IPV4HP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IPV4HP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/ipv4hp_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv4hp_pkg
// Types, constants and helpers shared by the IPv4 header parser modules.
// ----------------------------------------------------------------------------
package ipv4hp_pkg;

   localparam int COUNT_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [3:0] VERSION_IPV4 = 4'd4;
   localparam logic [3:0] MIN_WORDS    = 4'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_VER   = 2'd1;
   localparam logic [1:0] STATUS_SHORT_HDR = 2'd2;
   localparam logic [1:0] STATUS_TRUNC     = 2'd3;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   localparam logic [5:0] POS_VER       = 6'd0;
   localparam logic [5:0] POS_LEN_HI    = 6'd2;
   localparam logic [5:0] POS_LEN_LO    = 6'd3;
   localparam logic [5:0] POS_TTL       = 6'd8;
   localparam logic [5:0] POS_PROTO     = 6'd9;
   localparam logic [5:0] POS_SRC_FIRST = 6'd12;
   localparam logic [5:0] POS_SRC_LAST  = 6'd15;
   localparam logic [5:0] POS_DST_FIRST = 6'd16;
   localparam logic [5:0] POS_DST_LAST  = 6'd19;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_DISCARD = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  version;
      logic [3:0]  header_words;
      logic [15:0] datagram_length;
      logic [7:0]  hop_limit;
      logic [7:0]  protocol_number;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] payload_length;
      logic [15:0] trimmed_bytes;
   } report_type;

   typedef struct packed {
      logic       has_payload;
      logic [7:0] payload_byte;
      logic       has_report;
      report_type report;
   } entry_type;

   function automatic logic [15:0] sat16(input logic [31:0] v);
      return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
   endfunction

endpackage

@@ design/ipv4_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ipv4_header_parser_unit
// IPv4 header parser: header fields, payload forwarding with trim, end report.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle. Each byte yields at most one entry in a
// QUEUE_DEPTH-deep queue; the back end turns an entry into one output beat per
// cycle unless output stalls, or two when a packet's last byte is also forwarded
// (payload beat, then report beat). Entries pass the queue, then the output
// register. Input stalls only when the queue is full, i.e. when output stalls
// persist or end-of-packet bytes that also forward payload come back to back.
module ipv4_header_parser_unit #(
   parameter int COUNT_BITS  = ipv4hp_pkg::COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = ipv4hp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_packet,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_record_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_version,
   output logic [3:0]  rsp_header_words,
   output logic [15:0] rsp_total_length,
   output logic [7:0]  rsp_hop_limit,
   output logic [7:0]  rsp_protocol_number,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_destination_address,
   output logic [15:0] rsp_payload_length,
   output logic [15:0] rsp_trimmed_bytes
);

   logic                  queue_full;
   logic                  push_valid;
   ipv4hp_pkg::entry_type push_entry;
   logic                  pop;
   logic                  head_valid;
   ipv4hp_pkg::entry_type head_entry;

   ipv4hp_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_packet (req_end_of_packet),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_entry        (push_entry)
   );

   ipv4hp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ipv4hp_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .head_valid              (head_valid),
      .head_entry              (head_entry),
      .pop                     (pop),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_record_kind         (rsp_record_kind),
      .rsp_payload_byte        (rsp_payload_byte),
      .rsp_status              (rsp_status),
      .rsp_version             (rsp_version),
      .rsp_header_words        (rsp_header_words),
      .rsp_total_length        (rsp_total_length),
      .rsp_hop_limit           (rsp_hop_limit),
      .rsp_protocol_number     (rsp_protocol_number),
      .rsp_source_address      (rsp_source_address),
      .rsp_destination_address (rsp_destination_address),
      .rsp_payload_length      (rsp_payload_length),
      .rsp_trimmed_bytes       (rsp_trimmed_bytes)
   );

endmodule

@@ design/ipv4hp_front.sv @@
// ----------------------------------------------------------------------------
// ipv4hp_front
// Per-beat header parse, payload trim and report build; one beat per cycle unless the queue is full.
// ----------------------------------------------------------------------------
module ipv4hp_front #(
   parameter int COUNT_BITS = ipv4hp_pkg::COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_packet,
   input  logic                  queue_full,
   output logic                  push_valid,
   output ipv4hp_pkg::entry_type push_entry
);

   ipv4hp_pkg::phase_type phase_ff, phase_in;
   logic [5:0]            pos_ff, pos_in;
   logic [1:0]            err_ff, err_in;
   logic [3:0]            version_ff, version_in;
   logic [3:0]            words_ff, words_in;
   logic [15:0]           length_ff, length_in;
   logic [7:0]            ttl_ff, ttl_in;
   logic [7:0]            proto_ff, proto_in;
   logic [31:0]           src_ff, src_in;
   logic [31:0]           dst_ff, dst_in;
   logic [COUNT_BITS-1:0] fwd_ff, fwd_in;
   logic [COUNT_BITS-1:0] drop_ff, drop_in;

   logic        accept;
   logic        forward;
   logic [5:0]  hdr_last;
   logic [15:0] hdr_bytes;
   logic [15:0] limit;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign hdr_last  = {words_ff - 4'd1, 2'b11};
   assign hdr_bytes = {10'd0, words_ff, 2'b00};
   assign limit     = length_ff - hdr_bytes;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      err_in     = err_ff;
      version_in = version_ff;
      words_in   = words_ff;
      length_in  = length_ff;
      ttl_in     = ttl_ff;
      proto_in   = proto_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      fwd_in     = fwd_ff;
      drop_in    = drop_ff;
      forward    = 1'b0;

      case (phase_ff)
         ipv4hp_pkg::PH_HEADER: begin
            pos_in = pos_ff + 6'd1;
            case (pos_ff)
               ipv4hp_pkg::POS_VER: begin
                  version_in = req_data_byte[7:4];
                  words_in   = req_data_byte[3:0];
                  if (req_data_byte[7:4] != ipv4hp_pkg::VERSION_IPV4) begin
                     err_in = ipv4hp_pkg::STATUS_BAD_VER;
                  end else if (req_data_byte[3:0] < ipv4hp_pkg::MIN_WORDS) begin
                     err_in = ipv4hp_pkg::STATUS_SHORT_HDR;
                  end
               end
               ipv4hp_pkg::POS_LEN_HI: length_in = {req_data_byte, 8'h00};
               ipv4hp_pkg::POS_LEN_LO: length_in = {length_ff[15:8], req_data_byte};
               ipv4hp_pkg::POS_TTL:    ttl_in    = req_data_byte;
               ipv4hp_pkg::POS_PROTO:  proto_in  = req_data_byte;
               default: begin
                  if (pos_ff >= ipv4hp_pkg::POS_SRC_FIRST &&
                      pos_ff <= ipv4hp_pkg::POS_SRC_LAST) begin
                     src_in = {src_ff[23:0], req_data_byte};
                  end else if (pos_ff >= ipv4hp_pkg::POS_DST_FIRST &&
                               pos_ff <= ipv4hp_pkg::POS_DST_LAST) begin
                     dst_in = {dst_ff[23:0], req_data_byte};
                  end
               end
            endcase
            if (err_in != ipv4hp_pkg::STATUS_OK) begin
               phase_in = ipv4hp_pkg::PH_DISCARD;
            end else if (pos_ff != ipv4hp_pkg::POS_VER && pos_ff == hdr_last) begin
               phase_in = ipv4hp_pkg::PH_PAYLOAD;
            end else if (req_end_of_packet) begin
               err_in = ipv4hp_pkg::STATUS_TRUNC;
            end
         end
         ipv4hp_pkg::PH_PAYLOAD: begin
            forward = !(length_ff >= hdr_bytes && fwd_ff >= COUNT_BITS'(limit));
            if (forward) begin
               fwd_in = (fwd_ff == '1) ? fwd_ff : fwd_ff + COUNT_BITS'(1);
            end else begin
               drop_in = (drop_ff == '1) ? drop_ff : drop_ff + COUNT_BITS'(1);
            end
         end
         default: begin
         end
      endcase

      push_entry.has_payload                 = forward;
      push_entry.payload_byte                = req_data_byte;
      push_entry.has_report                  = req_end_of_packet;
      push_entry.report.status               = err_in;
      push_entry.report.version              = version_in;
      push_entry.report.header_words         = words_in;
      push_entry.report.datagram_length      = length_in;
      push_entry.report.hop_limit            = ttl_in;
      push_entry.report.protocol_number      = proto_in;
      push_entry.report.source_address       = src_in;
      push_entry.report.destination_address  = dst_in;
      push_entry.report.payload_length       = ipv4hp_pkg::sat16(32'(fwd_in));
      push_entry.report.trimmed_bytes        = ipv4hp_pkg::sat16(32'(drop_in));

      if (req_end_of_packet) begin
         phase_in   = ipv4hp_pkg::PH_HEADER;
         pos_in     = '0;
         err_in     = ipv4hp_pkg::STATUS_OK;
         version_in = '0;
         words_in   = '0;
         length_in  = '0;
         ttl_in     = '0;
         proto_in   = '0;
         src_in     = '0;
         dst_in     = '0;
         fwd_in     = '0;
         drop_in    = '0;
      end
   end

   assign push_valid = accept && (forward || req_end_of_packet);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ipv4hp_pkg::PH_HEADER;
         pos_ff     <= '0;
         err_ff     <= ipv4hp_pkg::STATUS_OK;
         version_ff <= '0;
         words_ff   <= '0;
         length_ff  <= '0;
         ttl_ff     <= '0;
         proto_ff   <= '0;
         src_ff     <= '0;
         dst_ff     <= '0;
         fwd_ff     <= '0;
         drop_ff    <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         err_ff     <= err_in;
         version_ff <= version_in;
         words_ff   <= words_in;
         length_ff  <= length_in;
         ttl_ff     <= ttl_in;
         proto_ff   <= proto_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         fwd_ff     <= fwd_in;
         drop_ff    <= drop_in;
      end
   end

endmodule

@@ design/ipv4hp_queue.sv @@
// ----------------------------------------------------------------------------
// ipv4hp_queue
// Small register FIFO of parsed entries between front and back.
// ----------------------------------------------------------------------------
module ipv4hp_queue #(
   parameter int DEPTH = ipv4hp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  ipv4hp_pkg::entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ipv4hp_pkg::entry_type head_entry
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ipv4hp_pkg::entry_type entry_ff [DEPTH];
   logic [IDX_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ design/ipv4hp_back.sv @@
// ----------------------------------------------------------------------------
// ipv4hp_back
// Unpacks queue entries into payload and report beats on the output register.
// ----------------------------------------------------------------------------
module ipv4hp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ipv4hp_pkg::entry_type head_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_record_kind,
   output logic [7:0]            rsp_payload_byte,
   output logic [1:0]            rsp_status,
   output logic [3:0]            rsp_version,
   output logic [3:0]            rsp_header_words,
   output logic [15:0]           rsp_total_length,
   output logic [7:0]            rsp_hop_limit,
   output logic [7:0]            rsp_protocol_number,
   output logic [31:0]           rsp_source_address,
   output logic [31:0]           rsp_destination_address,
   output logic [15:0]           rsp_payload_length,
   output logic [15:0]           rsp_trimmed_bytes
);

   logic                   valid_ff, valid_in;
   logic                   pay_done_ff, pay_done_in;
   logic                   kind_ff, kind_in;
   logic [7:0]             byte_ff, byte_in;
   ipv4hp_pkg::report_type rpt_ff, rpt_in;
   logic                   load;
   logic                   send_pay;

   assign load     = head_valid && (!valid_ff || !rsp_stall);
   assign send_pay = head_entry.has_payload && !pay_done_ff;

   always_comb begin
      valid_in    = valid_ff;
      pay_done_in = pay_done_ff;
      kind_in     = kind_ff;
      byte_in     = byte_ff;
      rpt_in      = rpt_ff;
      pop         = 1'b0;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         if (send_pay) begin
            kind_in     = ipv4hp_pkg::KIND_PAYLOAD;
            byte_in     = head_entry.payload_byte;
            rpt_in      = '0;
            pay_done_in = head_entry.has_report;
            pop         = !head_entry.has_report;
         end else begin
            kind_in     = ipv4hp_pkg::KIND_REPORT;
            byte_in     = '0;
            rpt_in      = head_entry.report;
            pay_done_in = 1'b0;
            pop         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pay_done_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         pay_done_ff <= pay_done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      rpt_ff  <= rpt_in;
   end

   assign rsp_valid               = valid_ff;
   assign rsp_record_kind         = kind_ff;
   assign rsp_payload_byte        = byte_ff;
   assign rsp_status              = rpt_ff.status;
   assign rsp_version             = rpt_ff.version;
   assign rsp_header_words        = rpt_ff.header_words;
   assign rsp_total_length        = rpt_ff.datagram_length;
   assign rsp_hop_limit           = rpt_ff.hop_limit;
   assign rsp_protocol_number     = rpt_ff.protocol_number;
   assign rsp_source_address      = rpt_ff.source_address;
   assign rsp_destination_address = rpt_ff.destination_address;
   assign rsp_payload_length      = rpt_ff.payload_length;
   assign rsp_trimmed_bytes       = rpt_ff.trimmed_bytes;

endmodule

@@ design/ipv4hp_checker.sv @@
// ----------------------------------------------------------------------------
// ipv4hp_checker
// Port-level assertions for the IPv4 header parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ipv4_header_parser_unit_macros.svh"

module ipv4hp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_record_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_version,
   input logic [3:0]  rsp_header_words,
   input logic [31:0] rsp_source_address,
   input logic [15:0] rsp_payload_length,
   input logic [15:0] rsp_trimmed_bytes
);

   `IPV4HP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_record_kind) && $stable(rsp_payload_byte) && $stable(rsp_payload_length), "rsp beat changed while stalled")
   `IPV4HP_ASSERT_IMPL(a_payload_clean, clock, reset, rsp_valid && rsp_record_kind == ipv4hp_pkg::KIND_PAYLOAD, rsp_status == ipv4hp_pkg::STATUS_OK && rsp_payload_length == 16'd0 && rsp_source_address == 32'd0, "payload beat carries report fields")
   `IPV4HP_ASSERT_IMPL(a_ok_header, clock, reset, rsp_valid && rsp_record_kind == ipv4hp_pkg::KIND_REPORT && rsp_status == ipv4hp_pkg::STATUS_OK, rsp_version == ipv4hp_pkg::VERSION_IPV4 && rsp_header_words >= ipv4hp_pkg::MIN_WORDS && rsp_payload_byte == 8'd0, "ok report with invalid header")
   `IPV4HP_ASSERT_IMPL(a_bad_version, clock, reset, rsp_valid && rsp_record_kind == ipv4hp_pkg::KIND_REPORT && rsp_status == ipv4hp_pkg::STATUS_BAD_VER, rsp_version != ipv4hp_pkg::VERSION_IPV4 && rsp_payload_length == 16'd0 && rsp_trimmed_bytes == 16'd0, "bad version report inconsistent")

endmodule

bind ipv4_header_parser_unit ipv4hp_checker u_checker (.*);
